[rtl/lpsfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsfr_pkg
// Shared types and constants for the length-prefixed SLIP frame receiver.
// ----------------------------------------------------------------------------
package lpsfr_pkg;

  // default payload buffer size in bytes; declared lengths stay below it
  localparam int unsigned MSG_MAX_DEF = 64;

  // framing bytes
  localparam logic [7:0] END_BYTE = 8'hC0;
  localparam logic [7:0] ESC_BYTE = 8'hDB;
  localparam logic [7:0] ESC_XOR  = 8'h20;
  localparam logic [7:0] MIN_LEN  = 8'd2;

  // configuration
  localparam logic [15:0] TIMEOUT_RESET    = 16'd100;
  localparam logic [1:0]  REG_IDLE_TIMEOUT = 2'd0;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_ABORT = 2'd3
  } kind_t;

  // one result request
  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic [5:0] frame_length;
  } result_t;

endpackage

[rtl/lpsfr_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsfr_core
// Frame state and per-request decode: frame start, unescaping, end check and
// idle timeout. Produces at most one result per accepted request.
// ----------------------------------------------------------------------------
module lpsfr_core import lpsfr_pkg::*; #(
  parameter int unsigned MSG_MAX = MSG_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic        command,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] idle_timeout_ms,
  output logic        res_valid,
  output result_t     res
);

  localparam int unsigned LEN_W = $clog2(MSG_MAX);
  localparam int unsigned CNT_W = $clog2(MSG_MAX + 1);

  logic [LEN_W-1:0] expected_length, expected_length_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;
  logic             escape_pending, escape_pending_next;
  logic [15:0]      idle_ticks, idle_ticks_next;

  logic             in_frame;
  logic             len_ok;
  logic             count_full;
  logic [7:0]       data_byte;

  assign in_frame   = (expected_length != '0);
  assign len_ok     = (rx_byte >= MIN_LEN) && ({1'b0, rx_byte} < 9'(MSG_MAX));
  assign count_full = (stored_count >= CNT_W'(MSG_MAX));
  assign data_byte  = escape_pending ? (rx_byte ^ ESC_XOR) : rx_byte;

  // next state and result for one request
  always_comb begin
    expected_length_next = expected_length;
    stored_count_next    = stored_count;
    escape_pending_next  = escape_pending;
    idle_ticks_next      = idle_ticks;
    res_valid            = 1'b0;
    res.kind             = KIND_DATA;
    res.payload_byte     = 8'h00;
    res.byte_index       = 6'(stored_count);
    res.frame_length     = 6'(expected_length);

    if (command) begin
      // millisecond tick
      if (in_frame) begin
        if (idle_ticks >= idle_timeout_ms) begin
          res_valid            = 1'b1;
          res.kind             = KIND_ABORT;
          expected_length_next = '0;
          escape_pending_next  = 1'b0;
        end else begin
          idle_ticks_next = idle_ticks + 16'd1;
        end
      end
    end else begin
      idle_ticks_next = '0;
      if (!in_frame) begin
        // length prefix opens a frame
        if (len_ok) begin
          expected_length_next = LEN_W'(rx_byte);
          stored_count_next    = '0;
          escape_pending_next  = 1'b0;
        end
      end else if (rx_byte == END_BYTE) begin
        res_valid            = 1'b1;
        res.kind             = (stored_count == CNT_W'(expected_length)) ? KIND_GOOD
                                                                         : KIND_BAD;
        expected_length_next = '0;
        escape_pending_next  = 1'b0;
      end else if (!count_full) begin
        if (rx_byte == ESC_BYTE) begin
          escape_pending_next = 1'b1;
        end else begin
          res_valid           = 1'b1;
          res.kind            = KIND_DATA;
          res.payload_byte    = data_byte;
          escape_pending_next = 1'b0;
          stored_count_next   = CNT_W'(stored_count + 1'b1);
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= '0;
      stored_count    <= '0;
      escape_pending  <= 1'b0;
      idle_ticks      <= '0;
    end else if (take) begin
      expected_length <= expected_length_next;
      stored_count    <= stored_count_next;
      escape_pending  <= escape_pending_next;
      idle_ticks      <= idle_ticks_next;
    end
  end

endmodule

[rtl/lpsfr_obuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsfr_obuf
// Output register with one skid entry, so the input side keeps flowing after
// the receiver stalls until a result has to be held in the skid entry.
// ----------------------------------------------------------------------------
module lpsfr_obuf import lpsfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_res,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    skid_valid;
  result_t skid_res;

  assign full = skid_valid;

  // head and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_res <= skid_valid ? skid_res : push_res;
    end else if (push) begin
      skid_res <= push_res;
    end
  end

endmodule

[rtl/length_prefixed_slip_frame_receiver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_slip_frame_receiver
// Deframes a SLIP-style, length-prefixed UART byte stream with idle timeout.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): each request is either a received byte
// (command 0, rx_byte) or a one millisecond tick (command 1).
// Output channel (out_valid / out_stall): zero or one result per request:
// a payload byte with its index, or a good end, bad end or timeout abort,
// each carrying the declared frame length.
// A result is decoded combinationally and registered in the output register
// (or the skid entry while stalled). Throughput: one request per cycle while
// in_stall is low, set by the single decode stage before the output register.
// Stall: the output register is backed by one skid entry; once that entry is
// occupied in_stall rises until the receiver takes the waiting result.
// Reset: no frame open, no result pending, idle_timeout_ms back to 100.
// Configuration: APB, register 0 at byte address 0 holds idle_timeout_ms;
// write it only while no frame traffic is in flight.
// ----------------------------------------------------------------------------
module length_prefixed_slip_frame_receiver import lpsfr_pkg::*; #(
  parameter int unsigned MSG_MAX = MSG_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  rx_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [5:0]  byte_index,
  output logic [5:0]  frame_length
);

  logic [15:0] idle_timeout_ms;
  logic        take;
  logic        res_valid;
  result_t     res;
  result_t     out_res;
  logic        buf_full;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[3:2] == REG_IDLE_TIMEOUT) ? 32'(idle_timeout_ms) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout_ms <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[3:2] == REG_IDLE_TIMEOUT)) begin
      idle_timeout_ms <= pwdata[15:0];
    end
  end

  // request acceptance
  assign in_stall = buf_full;
  assign take     = in_valid && !in_stall;

  lpsfr_core #(
    .MSG_MAX (MSG_MAX)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .command         (command),
    .rx_byte         (rx_byte),
    .idle_timeout_ms (idle_timeout_ms),
    .res_valid       (res_valid),
    .res             (res)
  );

  lpsfr_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_res  (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // result fields
  assign kind         = out_res.kind;
  assign payload_byte = out_res.payload_byte;
  assign byte_index   = out_res.byte_index;
  assign frame_length = out_res.frame_length;

  // checks
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_held_result_stays: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_good_end_counts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_GOOD)) |-> (byte_index == frame_length))
    else $error("good end with mismatched count");

  a_end_no_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind != KIND_DATA)) |-> (payload_byte == 8'h00))
    else $error("frame end carries payload");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefixed SLIP frame receiver.
// A scoreboard class tracks the frame state and predicts each result. Tasks
// drive received bytes and millisecond ticks through the valid/stall input
// channel and set the idle timeout over APB. A directed opening is followed
// by random frames, broken frames, overflows, timeouts and noise under
// several timeout settings. Both channels idle in random bursts, and once the
// receiver holds off long enough for the block to fill and stall its input.
// ----------------------------------------------------------------------------
module tb_top import lpsfr_pkg::*; ();

  localparam logic       CMD_BYTE  = 1'b0;
  localparam logic       CMD_TICK  = 1'b1;
  localparam logic [1:0] REG_SPARE = 2'd1;
  localparam logic [3:0] ADDR_TIMEOUT = {REG_IDLE_TIMEOUT, 2'b00};
  localparam logic [3:0] ADDR_SPARE   = {REG_SPARE, 2'b00};
  localparam int unsigned PHASE_REQUESTS = 250;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned CYCLE_LIMIT    = 1000000;

  // frame state tracker and store of expected results
  class deframer_scoreboard;
    logic [15:0] timeout_ms;
    logic [5:0]  open_length;
    logic [6:0]  stored;
    logic        escape_armed;
    logic [15:0] quiet_ticks;
    result_t     expected_results[$];
    int unsigned failures;

    function new();
      timeout_ms   = TIMEOUT_RESET;
      open_length  = '0;
      stored       = '0;
      escape_armed = 1'b0;
      quiet_ticks  = '0;
      failures     = 0;
    endfunction

    function void set_timeout(logic [15:0] value);
      timeout_ms = value;
    endfunction

    function bit frame_open();
      return open_length != 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void push_result(kind_t k, logic [7:0] data);
      result_t r;
      r.kind         = k;
      r.payload_byte = data;
      r.byte_index   = stored[5:0];
      r.frame_length = open_length;
      expected_results.push_back(r);
    endfunction

    // update the frame state for one accepted request; returns 0 when ignored
    function bit note_request(logic cmd, logic [7:0] b);
      logic [7:0] data;
      data = b;
      if (cmd == CMD_TICK) begin
        if (open_length == 0) return 1'b0;
        if (quiet_ticks >= timeout_ms) begin
          push_result(KIND_ABORT, 8'h00);
          open_length  = '0;
          escape_armed = 1'b0;
        end else begin
          quiet_ticks++;
        end
        return 1'b1;
      end
      quiet_ticks = '0;
      // idle: only a legal length opens a frame
      if (open_length == 0) begin
        if (b >= MIN_LEN && b < MSG_MAX_DEF) begin
          open_length  = b[5:0];
          stored       = '0;
          escape_armed = 1'b0;
          return 1'b1;
        end
        return 1'b0;
      end
      if (b == END_BYTE) begin
        push_result((stored == {1'b0, open_length}) ? KIND_GOOD : KIND_BAD, 8'h00);
        open_length  = '0;
        escape_armed = 1'b0;
        return 1'b1;
      end
      // full buffer drops data and escapes
      if (stored >= MSG_MAX_DEF) return 1'b1;
      if (b == ESC_BYTE) begin
        escape_armed = 1'b1;
        return 1'b1;
      end
      if (escape_armed) begin
        escape_armed = 1'b0;
        data = b ^ ESC_XOR;
      end
      push_result(KIND_DATA, data);
      stored++;
      return 1'b1;
    endfunction

    function void check_result(logic [1:0] k, logic [7:0] pb, logic [5:0] idx,
                               logic [5:0] len);
      result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result: kind=%0d byte=%02h index=%0d length=%0d",
                         k, pb, idx, len));
        return;
      end
      want = expected_results.pop_front();
      if (k !== want.kind || pb !== want.payload_byte ||
          idx !== want.byte_index || len !== want.frame_length) begin
        report($sformatf({"mismatch: expected kind=%0d byte=%02h index=%0d length=%0d,",
                          " got kind=%0d byte=%02h index=%0d length=%0d"},
                         want.kind, want.payload_byte, want.byte_index, want.frame_length,
                         k, pb, idx, len));
      end
    endfunction

    function void check_timeout_readback(logic [15:0] got);
      if (got !== timeout_ms) begin
        report($sformatf("timeout readback: expected %0d, got %0d", timeout_ms, got));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic        command   = CMD_BYTE;
  logic [7:0]  rx_byte   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [5:0]  byte_index;
  logic [5:0]  frame_length;

  deframer_scoreboard sb = new();
  bit          quiet    = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned counted_requests = 0;

  length_prefixed_slip_frame_receiver i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .frame_length (frame_length)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      sb.check_result(kind, payload_byte, byte_index, frame_length);
    end
  end

  // receiver stall: random bursts, a long hold-off on request
  initial begin
    int  run;
    int  hold_left;
    bit  stalling;
    run       = 0;
    hold_left = 0;
    stalling  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        if (run == 0) begin
          stalling = ($urandom_range(0, 2) == 0);
          run      = $urandom_range(1, 16);
        end
        out_stall <= stalling;
        run--;
      end
    end
  end

  // offer one request and wait until it is taken; called and returns at negedge
  task automatic send_request(input logic cmd, input logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.note_request(cmd, b)) counted_requests++;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      send_request(CMD_TICK, 8'($urandom()));
    end
  endtask

  // payload byte with stuffing where needed, and now and then where not
  task automatic send_data(input logic [7:0] b);
    bit must_escape;
    bit may_escape;
    must_escape = (b == END_BYTE) || (b == ESC_BYTE);
    may_escape  = ((b ^ ESC_XOR) != END_BYTE) && ((b ^ ESC_XOR) != ESC_BYTE);
    if (must_escape || (may_escape && $urandom_range(0, 15) == 0)) begin
      send_request(CMD_BYTE, ESC_BYTE);
      send_request(CMD_BYTE, b ^ ESC_XOR);
    end else begin
      send_request(CMD_BYTE, b);
    end
  endtask

  function automatic logic [7:0] random_payload();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) == 0) ? END_BYTE : ESC_BYTE;
    return 8'($urandom());
  endfunction

  function automatic int random_length();
    if ($urandom_range(0, 7) == 0) return $urandom_range(MIN_LEN, MSG_MAX_DEF - 1);
    return $urandom_range(MIN_LEN, 10);
  endfunction

  // length byte, payload with a few ticks below the timeout, optional end
  task automatic send_frame(input int len, input int nbytes, input bit close);
    int budget;
    budget = (sb.timeout_ms > 3) ? 3 : int'(sb.timeout_ms);
    send_request(CMD_BYTE, 8'(len));
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 5) == 0) send_ticks($urandom_range(0, budget));
      send_data(random_payload());
    end
    if (close) send_request(CMD_BYTE, END_BYTE);
  endtask

  // open frame ends by timeout where that is short, else by an end byte
  task automatic finish_open_frame();
    if (sb.timeout_ms <= 40) begin
      send_ticks(int'(sb.timeout_ms) + 1);
    end else begin
      send_request(CMD_BYTE, END_BYTE);
    end
  endtask

  // at least as much payload as the buffer holds
  task automatic send_overflow();
    send_request(CMD_BYTE, 8'(random_length()));
    repeat (MSG_MAX_DEF + $urandom_range(0, 6)) send_data(random_payload());
    if ($urandom_range(0, 1) == 0) begin
      send_request(CMD_BYTE, ESC_BYTE);
      send_request(CMD_BYTE, END_BYTE);
    end else begin
      finish_open_frame();
    end
  endtask

  // mostly well-formed frames, the rest broken frames and noise
  task automatic run_random(input int unsigned quota, input bit pressure);
    int unsigned first;
    int          len;
    int          pick;
    bit          press;
    first = counted_requests;
    press = pressure;
    while (counted_requests - first < quota) begin
      if (press && counted_requests - first >= quota / 2) begin
        hold_req = 1'b1;
        press    = 1'b0;
      end
      pick = $urandom_range(0, 99);
      len  = random_length();
      if (pick < 82 && sb.frame_open()) send_request(CMD_BYTE, END_BYTE);
      if (pick < 60) begin
        send_frame(len, len, 1'b1);
      end else if (pick < 70) begin
        send_frame(len, $urandom_range(0, len + 3), 1'b1);
      end else if (pick < 78) begin
        send_frame(len, $urandom_range(0, len), 1'b0);
        finish_open_frame();
      end else if (pick < 82) begin
        send_overflow();
      end else begin
        repeat ($urandom_range(1, 6)) send_request(1'($urandom_range(0, 1)), 8'($urandom()));
      end
    end
  endtask

  // stop offering and let every expected result arrive
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_TIMEOUT) sb.set_timeout(data[15:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_check_timeout();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_TIMEOUT;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.check_timeout_readback(prdata[15:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_timeout_reg(input logic [15:0] value);
    apb_write(ADDR_TIMEOUT, {16'h0000, value});
    apb_check_timeout();
  endtask

  // main sequence
  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    apb_check_timeout();

    // idle tick and out-of-range idle bytes are ignored
    send_request(CMD_TICK, 8'hFF);
    send_request(CMD_BYTE, 8'd0);
    send_request(CMD_BYTE, 8'd1);
    send_request(CMD_BYTE, 8'(MSG_MAX_DEF));
    send_request(CMD_BYTE, 8'hFF);
    send_request(CMD_BYTE, END_BYTE);
    // shortest frame, repeated escape, good end
    send_request(CMD_BYTE, MIN_LEN);
    send_request(CMD_BYTE, 8'h00);
    send_request(CMD_BYTE, ESC_BYTE);
    send_request(CMD_BYTE, ESC_BYTE);
    send_request(CMD_BYTE, END_BYTE ^ ESC_XOR);
    send_request(CMD_BYTE, END_BYTE);
    // longest length, tick inside, escape left pending at the end
    send_request(CMD_BYTE, 8'(MSG_MAX_DEF - 1));
    send_request(CMD_BYTE, 8'hFF);
    send_request(CMD_TICK, 8'h00);
    send_request(CMD_BYTE, ESC_BYTE);
    send_request(CMD_BYTE, END_BYTE);
    // count above length
    send_request(CMD_BYTE, MIN_LEN);
    send_request(CMD_BYTE, 8'h11);
    send_request(CMD_BYTE, 8'h22);
    send_request(CMD_BYTE, 8'h33);
    send_request(CMD_BYTE, END_BYTE);
    // buffer overflow
    send_overflow();
    wait_drain();

    // spare register address must leave the timeout alone
    set_timeout_reg(16'd3);
    apb_write(ADDR_SPARE, 32'h0000_0001);
    apb_check_timeout();
    run_random(PHASE_REQUESTS, 1'b0);
    wait_drain();

    set_timeout_reg(16'd1);
    run_random(PHASE_REQUESTS, 1'b1);
    wait_drain();

    // zero timeout aborts on the first tick
    set_timeout_reg(16'd0);
    run_random(PHASE_REQUESTS, 1'b0);
    wait_drain();

    set_timeout_reg(16'd12);
    run_random(PHASE_REQUESTS, 1'b0);
    wait_drain();

    // largest timeout: ticks leave the open frame alone, then a full-length good frame
    quiet = 1'b1;
    set_timeout_reg(16'hFFFF);
    send_frame(5, 2, 1'b0);
    send_ticks(40);
    send_request(CMD_BYTE, END_BYTE);
    send_frame(MSG_MAX_DEF - 1, MSG_MAX_DEF - 1, 1'b1);
    wait_drain();

    set_timeout_reg(16'd2);
    run_random(PHASE_REQUESTS, 1'b0);
    wait_drain();

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
